// ===== hdl/gpr_pkg.sv =====
// shared types and constants for the glyph page rasterizer
package gpr_pkg;

	localparam int SCREEN_WIDTH  = 128;
	localparam int SCREEN_HEIGHT = 64;

	localparam logic ACT_SET_POS = 1'b0;
	localparam logic ACT_DRAW    = 1'b1;

	localparam logic KIND_WINDOW = 1'b0;
	localparam logic KIND_DATA   = 1'b1;

	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	typedef struct packed {
		logic load;
		logic emit_set;
		logic emit_win;
		logic emit_data;
	} gpr_cmd_t;

	typedef struct packed {
		logic last_col;
		logic last_page;
	} gpr_status_t;

endpackage

// ===== hdl/glyph_page_rasterizer.sv =====
// top level of the glyph page rasterizer
// Renders 8x8 glyphs as column bytes for a page-organized 128x64 display and keeps a text
// cursor. One item is worked on at a time. A set-position item emits a single window beat, which
// enters the output register from the SETW state once that register can take it. A draw item
// emits, for each of the 1 to 3 pages it touches, one window beat and then 8 (scale 0 or 1) or
// 16 (scale 2 or 3) column-byte beats, one beat per cycle from the output register; the
// sequencer walks pages and columns one beat at a time and a new item is taken once the final
// beat is in the output register. Output stalls hold the sequencer in place.
module glyph_page_rasterizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  row,
	input  logic [7:0]  col,
	input  logic [63:0] glyph,
	input  logic [1:0]  scale,
	input  logic [1:0]  rotation,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        kind,
	output logic [2:0]  page,
	output logic [6:0]  col_first,
	output logic [6:0]  col_end,
	output logic [7:0]  pixels,
	output logic        last
);
	import gpr_pkg::*;

	gpr_cmd_t    cmd;
	gpr_status_t status;

	gpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.action    (action),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	gpr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.action    (action),
		.row       (row),
		.col       (col),
		.glyph     (glyph),
		.scale     (scale),
		.rotation  (rotation),
		.kind      (kind),
		.page      (page),
		.col_first (col_first),
		.col_end   (col_end),
		.pixels    (pixels),
		.last      (last)
	);

`ifndef NO_ASSERTIONS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while an item is in progress");

	a_partial_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |-> !in_ready)
		else $error("ready while an item still has beats to send");

	a_data_single_col: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_DATA) |-> (col_first == col_end))
		else $error("data beat with a column range");

	a_window_no_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_WINDOW) |-> (pixels == 8'd0))
		else $error("window beat carries pixels");
`endif

endmodule

// ===== hdl/gpr_ctrl.sv =====
// sequencing state machine for the glyph page rasterizer
module gpr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                action,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  gpr_pkg::gpr_status_t status,
	output gpr_pkg::gpr_cmd_t   cmd
);
	import gpr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETW,
		ST_WIN,
		ST_DATA
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   emit_ok;

	assign emit_ok   = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.load      = (state_q == ST_IDLE) && in_valid;
		cmd.emit_set  = (state_q == ST_SETW) && emit_ok;
		cmd.emit_win  = (state_q == ST_WIN) && emit_ok;
		cmd.emit_data = (state_q == ST_DATA) && emit_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit_set || cmd.emit_win || cmd.emit_data) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= (action == ACT_DRAW) ? ST_WIN : ST_SETW;
					end
				end
				ST_SETW: begin
					if (emit_ok) begin
						state_q <= ST_IDLE;
					end
				end
				ST_WIN: begin
					if (emit_ok) begin
						state_q <= ST_DATA;
					end
				end
				ST_DATA: begin
					if (emit_ok && status.last_col) begin
						state_q <= status.last_page ? ST_IDLE : ST_WIN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/gpr_dp.sv =====
// cursor, glyph sampling and result registers of the glyph page rasterizer
module gpr_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  gpr_pkg::gpr_cmd_t    cmd,
	output gpr_pkg::gpr_status_t status,
	input  logic                 action,
	input  logic [7:0]           row,
	input  logic [7:0]           col,
	input  logic [63:0]          glyph,
	input  logic [1:0]           scale,
	input  logic [1:0]           rotation,
	output logic                 kind,
	output logic [2:0]           page,
	output logic [6:0]           col_first,
	output logic [6:0]           col_end,
	output logic [7:0]           pixels,
	output logic                 last
);
	import gpr_pkg::*;

	logic [6:0]  cur_col_q;
	logic [5:0]  cur_row_q;
	logic [63:0] glyph_q;
	logic [1:0]  rot_q;
	logic        big_q;
	logic [1:0]  p_q;
	logic [3:0]  x_q;

	logic        kind_q;
	logic [2:0]  page_q;
	logic [6:0]  cs_q;
	logic [6:0]  ce_q;
	logic [7:0]  pix_q;
	logic        last_q;

	logic [4:0]  size5;
	logic [3:0]  size_m1;
	logic [6:0]  row_end;
	logic [3:0]  span;
	logic [3:0]  pgu;
	logic        wrapped;
	logic [6:0]  win_end;
	logic [6:0]  data_col;
	logic [7:0]  byte_pix;
	logic        last_col;
	logic        last_page;

	logic [7:0]  cc_add;
	logic [6:0]  cr_add;
	logic        cc_fit;
	logic        cr_fit;
	logic        cc_ge;
	logic        cr_ge;
	logic [6:0]  cc_back;
	logic [5:0]  cr_back;
	logic [6:0]  cc_next;
	logic [5:0]  cr_next;
	logic [5:0]  set_row;

	assign size5     = big_q ? 5'd16 : 5'd8;
	assign size_m1   = big_q ? 4'd15 : 4'd7;
	assign row_end   = {1'b0, cur_row_q} + {2'b0, size5} - 7'd1;
	assign span      = row_end[6:3] - {1'b0, cur_row_q[5:3]};
	assign pgu       = {1'b0, cur_row_q[5:3]} + {2'b0, p_q};
	assign wrapped   = pgu[3];
	assign win_end   = cur_col_q + {2'b0, size5} - 7'd1;
	assign data_col  = cur_col_q + {3'b0, x_q};
	assign last_col  = (x_q == size_m1);
	assign last_page = (p_q == span[1:0]);

	assign status.last_col  = last_col;
	assign status.last_page = last_page;

	always_comb begin
		logic [7:0] diff;
		logic [3:0] y;
		logic [3:0] rx;
		logic [3:0] ry;
		logic [3:0] sx;
		logic [3:0] sy;
		byte_pix = '0;
		for (int b = 0; b < 8; b++) begin
			diff = {2'b0, pgu[2:0], 3'(b)} - {2'b0, cur_row_q};
			y    = diff[3:0];
			case (rot_q)
				ROT_0: begin
					rx = x_q;
					ry = y;
				end
				ROT_90: begin
					rx = y;
					ry = size_m1 - x_q;
				end
				ROT_180: begin
					rx = size_m1 - x_q;
					ry = size_m1 - y;
				end
				default: begin
					rx = size_m1 - y;
					ry = x_q;
				end
			endcase
			sx = big_q ? (rx >> 1) : rx;
			sy = big_q ? (ry >> 1) : ry;
			if (!wrapped && !diff[7] && (diff[6:0] < {2'b0, size5})) begin
				byte_pix[b] = glyph_q[{sy[2:0], sx[2:0]}];
			end
		end
	end

	assign cc_add  = {1'b0, cur_col_q} + {3'b0, size5};
	assign cr_add  = {1'b0, cur_row_q} + {2'b0, size5};
	assign cc_fit  = cc_add < 8'(SCREEN_WIDTH);
	assign cr_fit  = cr_add < 7'(SCREEN_HEIGHT);
	assign cc_ge   = cur_col_q >= {2'b0, size5};
	assign cr_ge   = cur_row_q >= {1'b0, size5};
	assign cc_back = 7'(8'(SCREEN_WIDTH) - {3'b0, size5});
	assign cr_back = 6'(7'(SCREEN_HEIGHT) - {2'b0, size5});
	assign set_row = (row < 8'(SCREEN_HEIGHT)) ? row[5:0] : 6'(SCREEN_HEIGHT - 1);

	always_comb begin
		cc_next = cur_col_q;
		cr_next = cur_row_q;
		case (rot_q)
			ROT_0: begin
				if (cc_fit) begin
					cc_next = cc_add[6:0];
				end else begin
					cc_next = '0;
					cr_next = cr_fit ? cr_add[5:0] : 6'd0;
				end
			end
			ROT_90: begin
				if (cr_fit) begin
					cr_next = cr_add[5:0];
				end else begin
					cr_next = '0;
					cc_next = cc_ge ? (cur_col_q - {2'b0, size5}) : cc_back;
				end
			end
			ROT_180: begin
				if (cc_ge) begin
					cc_next = cur_col_q - {2'b0, size5};
				end else begin
					cc_next = cc_back;
					cr_next = cr_ge ? (cur_row_q - {1'b0, size5}) : cr_back;
				end
			end
			default: begin
				if (cr_ge) begin
					cr_next = cur_row_q - {1'b0, size5};
				end else begin
					cr_next = cr_back;
					cc_next = cc_fit ? cc_add[6:0] : 7'd0;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			p_q       <= '0;
			x_q       <= '0;
		end else begin
			if (cmd.load) begin
				p_q <= '0;
				x_q <= '0;
				if (action == ACT_SET_POS) begin
					cur_col_q <= col[6:0];
					cur_row_q <= set_row;
				end
			end
			if (cmd.emit_data) begin
				x_q <= last_col ? 4'd0 : x_q + 4'd1;
				if (last_col) begin
					p_q <= p_q + 2'd1;
				end
				if (last_col && last_page) begin
					cur_col_q <= cc_next;
					cur_row_q <= cr_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			glyph_q <= glyph;
			rot_q   <= rotation;
			big_q   <= scale[1];
		end
		if (cmd.emit_set) begin
			kind_q <= KIND_WINDOW;
			page_q <= cur_row_q[5:3];
			cs_q   <= cur_col_q;
			ce_q   <= cur_col_q;
			pix_q  <= '0;
			last_q <= 1'b1;
		end
		if (cmd.emit_win) begin
			kind_q <= KIND_WINDOW;
			page_q <= pgu[2:0];
			cs_q   <= cur_col_q;
			ce_q   <= win_end;
			pix_q  <= '0;
			last_q <= 1'b0;
		end
		if (cmd.emit_data) begin
			kind_q <= KIND_DATA;
			page_q <= pgu[2:0];
			cs_q   <= data_col;
			ce_q   <= data_col;
			pix_q  <= byte_pix;
			last_q <= last_col && last_page;
		end
	end

	assign kind      = kind_q;
	assign page      = page_q;
	assign col_first = cs_q;
	assign col_end   = ce_q;
	assign pixels    = pix_q;
	assign last      = last_q;

endmodule
